FILE: rtl/rvu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvu_pkg
// Shared widths and constants of the refraction vector unit.
// ----------------------------------------------------------------------------
package rvu_pkg;

  localparam int NORM_W  = 16;   // normal component, Q2.14
  localparam int ETA_W   = 16;   // index ratio, Q4.12
  localparam int OUT_W   = 18;   // result component, Q3.15
  localparam int SH_W    = 5;    // normalization shift amount
  localparam int SHIFT_W = 32;   // normalized magnitude
  localparam int U_FRAC  = 30;   // fraction bits of the unit vector
  localparam int SQ_W    = 64;   // square-root radicand
  localparam int ROOT_W  = SQ_W / 2;
  localparam int NUM_W   = 63;   // dividend of the normalize divide
  localparam int QUO_W   = 31;   // quotient, at most 2^30

  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

endpackage

FILE: rtl/rvu_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvu_delay
// Enabled shift line that keeps side data aligned with the pipelined units.
// ----------------------------------------------------------------------------
module rvu_delay #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int k = 1; k < N; k++) begin
        sr[k] <= sr[k-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

FILE: rtl/rvu_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvu_isqrt
// Pipelined integer square root, floor(sqrt(x)), one root bit per stage.
// ----------------------------------------------------------------------------
module rvu_isqrt #(
  parameter int IN_W = rvu_pkg::SQ_W
) (
  input  logic              clk,
  input  logic              en,
  input  logic [IN_W-1:0]   x,
  output logic [IN_W/2-1:0] root
);

  localparam int RW = IN_W / 2;

  logic [IN_W-1:0] rem_p  [RW-1];
  logic [RW-1:0]   root_p [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [IN_W-1:0] rem_in;
    logic [IN_W-1:0] trial;
    logic [RW-1:0]   root_in;
    logic            take;

    if (k == 0) begin : g_first
      assign rem_in  = x;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_p[k-1];
      assign root_in = root_p[k-1];
    end

    assign trial = (IN_W'(root_in) << (B + 1)) | (IN_W'(1) << (2 * B));
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_p[k] <= take ? (root_in | (RW'(1) << B)) : root_in;
      end
    end

    if (k < RW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_p[k] <= take ? (rem_in - trial) : rem_in;
        end
      end
    end
  end

  assign root = root_p[RW-1];

endmodule

FILE: rtl/rvu_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvu_divider
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module rvu_divider #(
  parameter int NUM_W = rvu_pkg::NUM_W,
  parameter int DEN_W = rvu_pkg::ROOT_W,
  parameter int QUO_W = rvu_pkg::QUO_W
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [NUM_W-1:0] rem_p [QUO_W-1];
  logic [DEN_W-1:0] den_p [QUO_W-1];
  logic [QUO_W-1:0] quo_p [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int B = QUO_W - 1 - k;
    logic [NUM_W-1:0] rem_in;
    logic [NUM_W-1:0] trial;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_p[k-1];
      assign den_in = den_p[k-1];
      assign quo_in = quo_p[k-1];
    end

    assign trial = NUM_W'(den_in) << B;
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_p[k] <= {quo_in[QUO_W-2:0], take};
      end
    end

    if (k < QUO_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_p[k] <= take ? (rem_in - trial) : rem_in;
          den_p[k] <= den_in;
        end
      end
    end
  end

  assign quo = quo_p[QUO_W-1];

endmodule

FILE: rtl/refraction_vector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refraction_vector_unit
// Snell refraction of a direction against a surface normal, fixed point.
// Throughput: one request per cycle; the whole pipeline holds while the
// result register is stalled.
// Reset clears the valid bits of the pipeline only; data registers are not
// reset. Two 32-stage square roots and a 31-stage divider set the depth.
// ----------------------------------------------------------------------------
module refraction_vector_unit #(
  parameter int DIR_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [DIR_BITS-1:0]          dir_x,
  input  logic signed [DIR_BITS-1:0]          dir_y,
  input  logic signed [DIR_BITS-1:0]          dir_z,
  input  logic signed [rvu_pkg::NORM_W-1:0]   norm_x,
  input  logic signed [rvu_pkg::NORM_W-1:0]   norm_y,
  input  logic signed [rvu_pkg::NORM_W-1:0]   norm_z,
  input  logic        [rvu_pkg::ETA_W-1:0]    index_ratio,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rvu_pkg::OUT_W-1:0]    out_x,
  output logic signed [rvu_pkg::OUT_W-1:0]    out_y,
  output logic signed [rvu_pkg::OUT_W-1:0]    out_z,
  output logic                                refracts
);

  localparam int NW      = rvu_pkg::NORM_W;
  localparam int EW      = rvu_pkg::ETA_W;
  localparam int SW      = rvu_pkg::SHIFT_W;
  localparam int ISQ_LAT = rvu_pkg::ROOT_W;
  localparam int DIV_LAT = rvu_pkg::QUO_W;
  localparam int LAT     = 5 + ISQ_LAT + DIV_LAT + 7 + ISQ_LAT + 2;
  localparam int D_ASH   = 2 + ISQ_LAT;
  localparam int D_FRONT = D_ASH + DIV_LAT;

  typedef struct packed {
    logic [2:0]         neg;
    logic               zero;
    logic [2:0][NW-1:0] n;
    logic [EW-1:0]      eta;
    logic [2*EW-1:0]    esq;
  } front_t;

  typedef struct packed {
    logic [2:0][39:0]   w;
    logic [2:0][NW-1:0] n;
    logic [EW-1:0]      eta;
    logic               ok;
  } back_t;

  logic           en;
  logic [LAT-1:0] vld;

  assign out_valid = vld[LAT-1];
  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // stage 1: capture
  logic signed [DIR_BITS-1:0] v1 [3];
  logic signed [NW-1:0]       n1 [3];
  logic        [EW-1:0]       eta1;

  always_ff @(posedge clk) begin
    if (en) begin
      v1[0] <= dir_x;
      v1[1] <= dir_y;
      v1[2] <= dir_z;
      n1[0] <= norm_x;
      n1[1] <= norm_y;
      n1[2] <= norm_z;
      eta1  <= index_ratio;
    end
  end

  // stage 2: magnitudes, max, eta squared
  logic [DIR_BITS-1:0] mag  [3];
  logic [DIR_BITS-1:0] mmax;
  logic [2*EW-1:0]     esq_w;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = v1[i][DIR_BITS-1] ? DIR_BITS'(-v1[i]) : DIR_BITS'(v1[i]);
    end
    mmax = mag[0];
    if (mag[1] > mmax) mmax = mag[1];
    if (mag[2] > mmax) mmax = mag[2];
  end

  assign esq_w = eta1 * eta1;

  logic [DIR_BITS-1:0] a2 [3];
  logic [2:0]          neg2;
  logic [DIR_BITS-1:0] m2;
  logic signed [NW-1:0] n2 [3];
  logic [EW-1:0]       eta2;
  logic [2*EW-1:0]     esq2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a2[i]   <= mag[i];
        neg2[i] <= v1[i][DIR_BITS-1];
        n2[i]   <= n1[i];
      end
      m2   <= mmax;
      eta2 <= eta1;
      esq2 <= esq_w;
    end
  end

  // stage 3: block normalize so the largest magnitude reaches 2^30
  logic [rvu_pkg::SH_W-1:0] msb;
  logic [rvu_pkg::SH_W-1:0] sh;

  always_comb begin
    msb = '0;
    for (int b = 0; b < DIR_BITS; b++) begin
      if (m2[b]) msb = rvu_pkg::SH_W'(b);
    end
    sh = (msb >= rvu_pkg::SH_W'(rvu_pkg::U_FRAC)) ? '0 :
         rvu_pkg::SH_W'(rvu_pkg::U_FRAC) - msb;
  end

  logic [2:0][SW-1:0] ash3;
  front_t             front3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ash3[i]     <= SW'(a2[i]) << sh;
        front3.n[i] <= n2[i];
      end
      front3.neg  <= neg2;
      front3.zero <= (m2 == '0);
      front3.eta  <= eta2;
      front3.esq  <= esq2;
    end
  end

  // stages 4-5: sum of squares
  logic [rvu_pkg::SQ_W-1:0] sqr4 [3];
  logic [rvu_pkg::SQ_W-1:0] sq5;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqr4[i] <= ash3[i] * ash3[i];
      end
      sq5 <= sqr4[0] + sqr4[1] + sqr4[2];
    end
  end

  logic [rvu_pkg::ROOT_W-1:0] len37;

  rvu_isqrt #(.IN_W(rvu_pkg::SQ_W)) u_len_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (sq5),
    .root (len37)
  );

  logic [2:0][SW-1:0] ash37;

  rvu_delay #(.W(3 * SW), .N(D_ASH)) u_ash_dly (
    .clk (clk),
    .en  (en),
    .d   (ash3),
    .q   (ash37)
  );

  front_t front68;

  rvu_delay #(.W($bits(front_t)), .N(D_FRONT)) u_front_dly (
    .clk (clk),
    .en  (en),
    .d   (front3),
    .q   (front68)
  );

  logic [rvu_pkg::QUO_W-1:0] q68 [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    logic [rvu_pkg::NUM_W-1:0] num;
    assign num = (rvu_pkg::NUM_W'(ash37[i]) << rvu_pkg::U_FRAC) +
                 rvu_pkg::NUM_W'(len37 >> 1);
    rvu_divider #(
      .NUM_W (rvu_pkg::NUM_W),
      .DEN_W (rvu_pkg::ROOT_W),
      .QUO_W (rvu_pkg::QUO_W)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (num),
      .den (len37),
      .quo (q68[i])
    );
  end

  // stages 69-75: unit vector, dot product, discriminant, tangent term
  logic signed [31:0]   u69 [3];
  logic signed [NW-1:0] n69 [3];
  logic [EW-1:0]        eta69;
  logic [2*EW-1:0]      esq69;

  logic signed [47:0]   prod70 [3];
  logic signed [31:0]   u70 [3];
  logic signed [NW-1:0] n70 [3];
  logic [EW-1:0]        eta70;
  logic [2*EW-1:0]      esq70;

  logic signed [49:0]   acc;
  logic signed [33:0]   dt71;
  logic signed [31:0]   u71 [3];
  logic signed [NW-1:0] n71 [3];
  logic [EW-1:0]        eta71;
  logic [2*EW-1:0]      esq71;

  logic signed [67:0]   dt2_w;
  logic signed [49:0]   ndt_w [3];
  logic signed [63:0]   dt2_72;
  logic signed [49:0]   ndt72 [3];
  logic signed [31:0]   u72 [3];
  logic signed [NW-1:0] n72 [3];
  logic [EW-1:0]        eta72;
  logic [2*EW-1:0]      esq72;

  logic signed [63:0]   tx;
  logic signed [51:0]   y_w [3];
  logic signed [31:0]   t73;
  logic signed [39:0]   w73 [3];
  logic signed [NW-1:0] n73 [3];
  logic [EW-1:0]        eta73;
  logic [2*EW-1:0]      esq73;

  logic signed [64:0]   p_w;
  logic signed [63:0]   p74;
  logic signed [39:0]   w74 [3];
  logic signed [NW-1:0] n74 [3];
  logic [EW-1:0]        eta74;

  logic signed [63:0]   disc_w;
  logic signed [63:0]   disc75;
  back_t                back75;

  assign acc    = prod70[0] + prod70[1] + prod70[2] + 50'sd32768;
  assign dt2_w  = dt71 * dt71;
  assign tx     = 64'sh0100_0000_8000_0000 - dt2_72;
  assign p_w    = $signed({1'b0, esq73}) * t73;
  assign disc_w = 64'sh0001_0000_0000_0000 - p74;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ndt_w[i] = n71[i] * dt71;
      y_w[i]   = (52'(u72[i]) <<< 12) - 52'(ndt72[i]) + 52'sd2048;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (front68.zero) begin
          u69[i] <= '0;
        end else if (front68.neg[i]) begin
          u69[i] <= -$signed({1'b0, q68[i]});
        end else begin
          u69[i] <= $signed({1'b0, q68[i]});
        end
        n69[i]    <= $signed(front68.n[i]);
        prod70[i] <= u69[i] * n69[i];
        u70[i]    <= u69[i];
        n70[i]    <= n69[i];
        u71[i]    <= u70[i];
        n71[i]    <= n70[i];
        ndt72[i]  <= ndt_w[i];
        u72[i]    <= u71[i];
        n72[i]    <= n71[i];
        w73[i]    <= y_w[i][51:12];
        n73[i]    <= n72[i];
        w74[i]    <= w73[i];
        n74[i]    <= n73[i];
        back75.w[i] <= w74[i];
        back75.n[i] <= n74[i];
      end
      eta69  <= front68.eta;
      esq69  <= front68.esq;
      eta70  <= eta69;
      esq70  <= esq69;
      dt71   <= acc[49:16];
      eta71  <= eta70;
      esq71  <= esq70;
      dt2_72 <= dt2_w[63:0];
      eta72  <= eta71;
      esq72  <= esq71;
      t73    <= tx[63:32];
      eta73  <= eta72;
      esq73  <= esq72;
      p74    <= p_w[63:0];
      eta74  <= eta73;
      disc75     <= disc_w;
      back75.ok  <= disc_w > 64'sd0;
      back75.eta <= eta74;
    end
  end

  logic [rvu_pkg::SQ_W-1:0]   radicand;
  logic [rvu_pkg::ROOT_W-1:0] r107;
  back_t                      back107;

  assign radicand = back75.ok ? rvu_pkg::SQ_W'(disc75) : '0;

  rvu_isqrt #(.IN_W(rvu_pkg::SQ_W)) u_disc_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (radicand),
    .root (r107)
  );

  rvu_delay #(.W($bits(back_t)), .N(ISQ_LAT)) u_back_dly (
    .clk (clk),
    .en  (en),
    .d   (back75),
    .q   (back107)
  );

  // stages 108-109: combine, round, saturate, zero when the discriminant is not positive
  logic signed [56:0] ew108 [3];
  logic signed [48:0] nr108 [3];
  logic               ok108;
  logic signed [57:0] res_w [3];
  logic signed [30:0] o_w   [3];
  logic signed [rvu_pkg::OUT_W-1:0] sat_w [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ew108[i] <= $signed({1'b0, back107.eta}) * $signed(back107.w[i]);
        nr108[i] <= $signed(back107.n[i]) * $signed({1'b0, r107});
      end
      ok108 <= back107.ok;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_w[i] = 58'(ew108[i]) - (58'(nr108[i]) <<< 4) + 58'sd67108864;
      o_w[i]   = res_w[i][57:27];
      if (!ok108) begin
        sat_w[i] = '0;
      end else if (o_w[i] > 31'(rvu_pkg::OUT_MAX)) begin
        sat_w[i] = rvu_pkg::OUT_W'(rvu_pkg::OUT_MAX);
      end else if (o_w[i] < 31'(rvu_pkg::OUT_MIN)) begin
        sat_w[i] = rvu_pkg::OUT_W'(rvu_pkg::OUT_MIN);
      end else begin
        sat_w[i] = o_w[i][rvu_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= sat_w[0];
      out_y    <= sat_w[1];
      out_z    <= sat_w[2];
      refracts <= ok108;
    end
  end

endmodule
